/* rtl/core/substring_match_positions_defines.svh */
// Assertion macros shared by the substring match block.
// Plain text header with no dependencies; taken in by `include.
`ifndef SUBSTRING_MATCH_POSITIONS_DEFINES_SVH
`define SUBSTRING_MATCH_POSITIONS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/smp_pkg.sv */
// Package for the substring match block: beat types, register indexes and constants.
// No dependencies.
package smp_pkg;

    localparam int MAX_PATTERN_DEF   = 8;
    localparam int POSITION_BITS_DEF = 32;

    localparam int BYTE_W   = 8;
    localparam int OUT_W    = 32;
    localparam int PAT_W    = 64;
    localparam int PL_W     = 4;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0]    LEAD_BYTE = 8'hC3;
    localparam logic [OUT_W-1:0]     TALLY_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } t_in_beat;

    typedef struct packed {
        logic [OUT_W-1:0] match_start;
        logic [OUT_W-1:0] match_end;
        logic [OUT_W-1:0] total_matches;
        logic             is_count_report;
        logic             last_of_run;
    } t_out_beat;

endpackage

/* rtl/core/substring_match_positions.sv */
// Substring match block: window compare, position counters and result queue.
// Depends on smp_pkg and substring_match_positions_defines.svh.
//
// Usage: text bytes arrive as beats on the input channel (valid/ready), one byte
// per beat, end_of_text set on the final byte of a text. Each byte that ends a
// match yields one match beat; the final byte also yields a count report beat
// after any match beat. last_of_run marks the last beat caused by one byte.
// The pattern registers are to be written through the write port only while no
// text is in flight; the block itself does not enforce this.
// Flow: a byte accepted on the input channel is held in the input register,
// evaluated from there and written to a four-entry result queue; its first
// beat is offered on the output from the moment it is in the queue.
// Throughput: one byte per cycle while the queue has room; the window compare and
// counter update are combinational. Entries drain at one beat per cycle while the
// receiver is ready; a byte with both a match and a count report gives two beats.
// When the receiver stalls, the queue fills and input ready drops once no free
// entry remains, counting the byte held in the input register as one entry.
// Reset is synchronous and active low: the queue empties, all counters and the
// window clear, the pattern returns to all zero with length one. The end of a
// text clears the window and counters; the pattern registers are kept.
`include "substring_match_positions_defines.svh"

module substring_match_positions #(
    parameter int MAX_PATTERN   = smp_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = smp_pkg::POSITION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [smp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [smp_pkg::CFG_W-1:0]           i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  smp_pkg::t_in_beat                   i_in_beat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output smp_pkg::t_out_beat                  o_out_beat
);
    import smp_pkg::*;

    localparam int CHAR_W     = (POSITION_BITS < OUT_W) ? POSITION_BITS : OUT_W;
    localparam int WIN_IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [PL_W-1:0]   MAX_LEN    = PL_W'(MAX_PATTERN);
    localparam logic [CHAR_W-1:0] CHAR_MAX   = '1;
    localparam logic [CNT_W-1:0]  FIFO_LIMIT = CNT_W'(FIFO_DEPTH - 1);

    typedef struct packed {
        logic [CHAR_W-1:0] start_pos;
        logic [CHAR_W-1:0] end_pos;
        logic [OUT_W-1:0]  tally;
        logic              has_match;
        logic              has_report;
    } t_entry;

    logic [PAT_W-1:0]  r_pat_bytes;
    logic [PL_W-1:0]   r_pat_len;

    logic              r_in_valid;
    t_in_beat          r_in;

    logic [BYTE_W-1:0] r_win [MAX_PATTERN];
    logic [PL_W-1:0]   r_bytes;
    logic [CHAR_W-1:0] r_chars;
    logic [OUT_W-1:0]  r_tally;
    logic [PL_W-1:0]   r_skip;

    logic [BYTE_W-1:0] n_win [MAX_PATTERN];
    logic [PL_W-1:0]   n_bytes;
    logic [CHAR_W-1:0] n_chars;
    logic [OUT_W-1:0]  n_tally;
    logic [PL_W-1:0]   n_skip;

    t_entry            r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              r_sub;

    logic [PL_W-1:0]   w_len;
    logic [PL_W-1:0]   w_sel;
    logic [PL_W-1:0]   w_after;
    logic              w_hit;
    logic              w_push;
    t_entry            w_entry;
    t_entry            w_head;
    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_pop;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_count + CNT_W'(r_in_valid)) <= FIFO_LIMIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= PL_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PATTERN_BYTES:  r_pat_bytes <= i_cfg_wr_data[PAT_W-1:0];
                CFG_PATTERN_LENGTH: r_pat_len   <= i_cfg_wr_data[PL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_pat_len == '0) begin
            w_len = PL_W'(1);
        end else if (r_pat_len > MAX_LEN) begin
            w_len = MAX_LEN;
        end else begin
            w_len = r_pat_len;
        end

        n_win[0] = r_in.text_byte;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            n_win[i] = r_win[i-1];
        end

        n_bytes = (r_bytes < MAX_LEN) ? r_bytes + 1'b1 : r_bytes;
        n_chars = (r_in.text_byte != LEAD_BYTE && r_chars != CHAR_MAX) ?
                  r_chars + 1'b1 : r_chars;

        w_hit = (r_skip == '0) && (n_bytes >= w_len);
        w_sel = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (PL_W'(k) < w_len) begin
                w_sel = w_len - PL_W'(k) - 1'b1;
                if (n_win[w_sel[WIN_IDX_W-1:0]] != r_pat_bytes[BYTE_W*k +: BYTE_W]) begin
                    w_hit = 1'b0;
                end
            end
        end

        w_after = '0;
        for (int k = 0; k + 1 < MAX_PATTERN; k++) begin
            if (PL_W'(k + 1) < w_len && n_win[k] != LEAD_BYTE) begin
                w_after = w_after + 1'b1;
            end
        end

        n_tally = (w_hit && r_tally != TALLY_MAX) ? r_tally + 1'b1 : r_tally;

        if (r_skip != '0) begin
            n_skip = r_skip - 1'b1;
        end else if (w_hit) begin
            n_skip = w_len - 1'b1;
        end else begin
            n_skip = '0;
        end

        w_entry.start_pos  = (n_chars >= CHAR_W'(w_after)) ?
                             n_chars - CHAR_W'(w_after) : '0;
        w_entry.end_pos    = n_chars;
        w_entry.tally      = n_tally;
        w_entry.has_match  = w_hit;
        w_entry.has_report = r_in.end_of_text;

        w_push = r_in_valid && (w_hit || r_in.end_of_text);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_bytes    <= '0;
            r_chars    <= '0;
            r_tally    <= '0;
            r_skip     <= '0;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_in_valid <= w_in_acc;
            if (r_in_valid) begin
                if (r_in.end_of_text) begin
                    r_bytes <= '0;
                    r_chars <= '0;
                    r_tally <= '0;
                    r_skip  <= '0;
                    for (int i = 0; i < MAX_PATTERN; i++) begin
                        r_win[i] <= '0;
                    end
                end else begin
                    r_bytes <= n_bytes;
                    r_chars <= n_chars;
                    r_tally <= n_tally;
                    r_skip  <= n_skip;
                    for (int i = 0; i < MAX_PATTERN; i++) begin
                        r_win[i] <= n_win[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_beat;
        end
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_entry;
        end
    end

    assign w_head      = r_fifo[r_rd_ptr];
    assign o_out_valid = r_count != '0;
    assign w_out_acc   = o_out_valid && i_out_ready;

    always_comb begin
        if (w_head.has_match && !r_sub) begin
            o_out_beat.match_start     = OUT_W'(w_head.start_pos);
            o_out_beat.match_end       = OUT_W'(w_head.end_pos);
            o_out_beat.is_count_report = 1'b0;
            o_out_beat.last_of_run     = !w_head.has_report;
        end else begin
            o_out_beat.match_start     = '0;
            o_out_beat.match_end       = '0;
            o_out_beat.is_count_report = 1'b1;
            o_out_beat.last_of_run     = 1'b1;
        end
        o_out_beat.total_matches = w_head.tally;
    end

    assign w_pop = w_out_acc && o_out_beat.last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
                r_sub    <= 1'b0;
            end else if (w_out_acc) begin
                r_sub    <= 1'b1;
            end
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    `SMP_ASSERT_SAME(a_queue_room, i_clk, i_rst_n, r_in_valid, r_count <= FIFO_LIMIT, "result queue has no room for the evaluated byte")
    `SMP_ASSERT_NEXT(a_text_end_clears, i_clk, i_rst_n, r_in_valid && r_in.end_of_text, r_chars == '0 && r_tally == '0 && r_skip == '0, "counters not cleared after end of text")
    `SMP_ASSERT_NEXT(a_sub_clears, i_clk, i_rst_n, w_pop, !r_sub, "entry phase not cleared after its last beat")
    `SMP_ASSERT_SAME(a_start_le_end, i_clk, i_rst_n, o_out_valid && !o_out_beat.is_count_report, o_out_beat.match_start <= o_out_beat.match_end, "match starts after its end")

endmodule
